// ===== rtl/bls_pkg.sv =====
// bls_pkg: shared constants, register codes and structs of the bilinear scaler
// used by every file of the block; depends on nothing
`default_nettype none

package bls_pkg;

   // default store geometry and fixed-point format
   localparam int DEF_MAX_SRC_WIDTH  = 256;
   localparam int DEF_MAX_SRC_HEIGHT = 256;
   localparam int DEF_FRAC_BITS      = 16;

   // field widths
   localparam int COORD_W  = 12;
   localparam int PIX_W    = 8;
   localparam int FRAC_W   = 8;
   localparam int WGT_W    = 9;
   localparam int DIM_W    = 9;
   localparam int STEP_W   = 24;
   localparam int PROD_W   = COORD_W + STEP_W;
   localparam int DIMX_W   = COORD_W + 1;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_STEP   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_COL_STEP   = 2'd3;

   localparam logic [DIM_W-1:0]  RST_SRC_WIDTH  = 9'd256;
   localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT = 9'd256;
   localparam logic [STEP_W-1:0] RST_ROW_STEP   = 24'd65536;
   localparam logic [STEP_W-1:0] RST_COL_STEP   = 24'd65536;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [DIM_W-1:0]  src_width;
      logic [DIM_W-1:0]  src_height;
      logic [STEP_W-1:0] row_step;
      logic [STEP_W-1:0] col_step;
   } bls_cfg_type;

   // one classified request: a store write or an interpolation
   typedef struct packed {
      logic               is_write;
      logic               wr_ok;
      logic [COORD_W-1:0] r0;
      logic [COORD_W-1:0] r1;
      logic [COORD_W-1:0] c0;
      logic [COORD_W-1:0] c1;
      logic [FRAC_W-1:0]  fr;
      logic [FRAC_W-1:0]  fc;
      logic [PIX_W-1:0]   pixel;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } bls_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/bls_chan_if.sv =====
// bls_req_if and bls_rsp_if: valid/ready channels of the bilinear scaler
// depends on bls_pkg for field widths
`default_nettype none

interface bls_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [bls_pkg::COORD_W-1:0]   row;
   logic [bls_pkg::COORD_W-1:0]   col;
   logic [bls_pkg::PIX_W-1:0]     pixel_in;

   modport source (output valid, req_type, row, col, pixel_in, input ready);
   modport sink   (input valid, req_type, row, col, pixel_in, output ready);
endinterface

interface bls_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bls_pkg::PIX_W-1:0]     pixel_out;
   logic [bls_pkg::COORD_W-1:0]   out_row;
   logic [bls_pkg::COORD_W-1:0]   out_col;

   modport source (output valid, pixel_out, out_row, out_col, input ready);
   modport sink   (input valid, pixel_out, out_row, out_col, output ready);
endinterface

`default_nettype wire

// ===== rtl/bls_front.sv =====
// bls_front: accepts requests, scales coordinates and classifies them into commands
// depends on bls_pkg and bls_req_if
`default_nettype none

module bls_front #(
   parameter int MAX_SRC_WIDTH  = bls_pkg::DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = bls_pkg::DEF_MAX_SRC_HEIGHT,
   parameter int FRAC_BITS      = bls_pkg::DEF_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bls_req_if.sink                    req_ch,
   input  wire bls_pkg::bls_cfg_type  cfg,
   input  wire logic                  q_full,
   output logic                       q_push,
   output bls_pkg::bls_cmd_type       q_data
);

   localparam int CW = bls_pkg::COORD_W;
   localparam int PW = bls_pkg::PROD_W;
   localparam int XW = bls_pkg::DIMX_W;
   localparam int FW = bls_pkg::FRAC_W;
   localparam logic [XW-1:0] MAX_W_X = XW'(MAX_SRC_WIDTH);
   localparam logic [XW-1:0] MAX_H_X = XW'(MAX_SRC_HEIGHT);

   // last valid index of a dimension, the dimension first clamped to 1..max
   function automatic logic [CW-1:0] dim_last(input logic [bls_pkg::DIM_W-1:0] v,
                                              input logic [XW-1:0] maxv);
      logic [XW-1:0] d;
      begin
         d = XW'(v);
         if (d == '0) begin
            d = XW'(1);
         end else if (d > maxv) begin
            d = maxv;
         end
         return CW'(d - XW'(1));
      end
   endfunction

   // integer part of the position, saturated, and its clamped neighbour
   function automatic logic [2*CW-1:0] locate(input logic [PW-1:0] pos,
                                              input logic [CW-1:0] last);
      logic [PW-1:0] ip;
      logic [CW-1:0] i0;
      logic [CW-1:0] i1;
      begin
         ip = pos >> FRAC_BITS;
         i0 = (ip > PW'(last)) ? last : ip[CW-1:0];
         i1 = (i0 < last) ? i0 + CW'(1) : last;
         return {i1, i0};
      end
   endfunction

   logic                f1_valid_ff;
   logic                f1_type_ff;
   logic [CW-1:0]       f1_row_ff;
   logic [CW-1:0]       f1_col_ff;
   logic [bls_pkg::PIX_W-1:0] f1_pix_ff;
   logic [PW-1:0]       f1_prow_ff;
   logic [PW-1:0]       f1_pcol_ff;
   logic [PW-1:0]       f1_prow_in;
   logic [PW-1:0]       f1_pcol_in;

   logic                 f2_valid_ff;
   bls_pkg::bls_cmd_type f2_cmd_ff;
   bls_pkg::bls_cmd_type f2_cmd_in;

   logic                advance;
   logic [CW-1:0]       last_r;
   logic [CW-1:0]       last_c;
   logic [2*CW-1:0]     loc_r;
   logic [2*CW-1:0]     loc_c;

   // front stalls only when its last stage cannot enter the queue
   assign advance      = !f2_valid_ff || !q_full;
   assign req_ch.ready = advance;
   assign q_push       = f2_valid_ff && !q_full;
   assign q_data       = f2_cmd_ff;

   // stage one: coordinate times step
   assign f1_prow_in = PW'(req_ch.row) * PW'(cfg.row_step);
   assign f1_pcol_in = PW'(req_ch.col) * PW'(cfg.col_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_type_ff <= req_ch.req_type;
         f1_row_ff  <= req_ch.row;
         f1_col_ff  <= req_ch.col;
         f1_pix_ff  <= req_ch.pixel_in;
         f1_prow_ff <= f1_prow_in;
         f1_pcol_ff <= f1_pcol_in;
      end
   end

   // stage two: clamp indices, take fractions, check write range
   assign last_r = dim_last(cfg.src_height, MAX_H_X);
   assign last_c = dim_last(cfg.src_width, MAX_W_X);
   assign loc_r  = locate(f1_prow_ff, last_r);
   assign loc_c  = locate(f1_pcol_ff, last_c);

   always_comb begin
      f2_cmd_in.is_write = (f1_type_ff == bls_pkg::REQ_WRITE);
      f2_cmd_in.wr_ok    = (XW'(f1_row_ff) < MAX_H_X) && (XW'(f1_col_ff) < MAX_W_X);
      f2_cmd_in.r0       = f2_cmd_in.is_write ? f1_row_ff : loc_r[CW-1:0];
      f2_cmd_in.r1       = loc_r[2*CW-1:CW];
      f2_cmd_in.c0       = f2_cmd_in.is_write ? f1_col_ff : loc_c[CW-1:0];
      f2_cmd_in.c1       = loc_c[2*CW-1:CW];
      f2_cmd_in.fr       = f1_prow_ff[FRAC_BITS-1 -: FW];
      f2_cmd_in.fc       = f1_pcol_ff[FRAC_BITS-1 -: FW];
      f2_cmd_in.pixel    = f1_pix_ff;
      f2_cmd_in.row      = f1_row_ff;
      f2_cmd_in.col      = f1_col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f2_cmd_ff <= f2_cmd_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bls_queue.sv =====
// bls_queue: short command queue between the front and the back of the scaler
// depends on bls_pkg
`default_nettype none

module bls_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire bls_pkg::bls_cmd_type  push_data,
   output logic                       full,
   input  wire logic                  pop,
   output bls_pkg::bls_cmd_type       pop_data,
   output logic                       empty
);

   bls_pkg::bls_cmd_type                slot_ff [bls_pkg::QUEUE_DEPTH];
   logic [bls_pkg::QPTR_W-1:0]          wr_ptr_ff;
   logic [bls_pkg::QPTR_W-1:0]          rd_ptr_ff;
   logic [bls_pkg::QCNT_W-1:0]          count_ff;
   logic [bls_pkg::QPTR_W-1:0]          wr_ptr_in;
   logic [bls_pkg::QPTR_W-1:0]          rd_ptr_in;
   logic [bls_pkg::QCNT_W-1:0]          count_in;

   assign full     = (count_ff == bls_pkg::QCNT_W'(bls_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + bls_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + bls_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + bls_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bls_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bls_back.sv =====
// bls_back: four-bank frame store, weight math and weighted sum with output register
// depends on bls_pkg and bls_rsp_if
`default_nettype none

module bls_back #(
   parameter int MAX_SRC_WIDTH  = bls_pkg::DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = bls_pkg::DEF_MAX_SRC_HEIGHT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   output logic                       q_pop,
   input  wire bls_pkg::bls_cmd_type  q_data,
   bls_rsp_if.source                  rsp_ch
);

   localparam int CW         = bls_pkg::COORD_W;
   localparam int PXW        = bls_pkg::PIX_W;
   localparam int WW         = bls_pkg::WGT_W;
   localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
   localparam int CB         = (HALF_W > 1) ? $clog2(HALF_W) : 1;
   localparam int RB         = (HALF_H > 1) ? $clog2(HALF_H) : 1;
   localparam int AW         = RB + CB;
   localparam int BANK_DEPTH = 2 ** AW;
   localparam int PRW        = 2 * WW;
   localparam int SUMW       = PXW + WW + 1;

   logic                  en;
   logic [3:0][PXW-1:0]   rd_bank;

   logic [WW-1:0]         ir;
   logic [WW-1:0]         ic;
   logic [PRW-1:0]        w00_prod;
   logic [PRW-1:0]        w10_prod;
   logic [PRW-1:0]        w01_prod;
   logic [PRW-1:0]        w11_prod;

   logic                  b1_valid_ff;
   logic [WW-1:0]         w00_ff;
   logic [WW-1:0]         w10_ff;
   logic [WW-1:0]         w01_ff;
   logic [WW-1:0]         w11_ff;
   logic                  rs0_ff;
   logic                  rs1_ff;
   logic                  cs0_ff;
   logic                  cs1_ff;
   logic [CW-1:0]         b1_row_ff;
   logic [CW-1:0]         b1_col_ff;

   logic [PXW-1:0]        p00;
   logic [PXW-1:0]        p10;
   logic [PXW-1:0]        p01;
   logic [PXW-1:0]        p11;
   logic [SUMW-1:0]       sum;

   logic                  out_valid_ff;
   logic [PXW-1:0]        out_pix_ff;
   logic [CW-1:0]         out_row_ff;
   logic [CW-1:0]         out_col_ff;

   // the whole back moves unless a finished result is held
   assign en    = !out_valid_ff || rsp_ch.ready;
   assign q_pop = en && !q_empty;

   // one bank per row and column parity, one access per cycle each
   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic RP = 1'((b >> 1) & 1);
      localparam logic CP = 1'(b & 1);

      logic [PXW-1:0] mem [BANK_DEPTH];
      logic [PXW-1:0] rd_ff;
      logic [CW-1:0]  rsel;
      logic [CW-1:0]  csel;
      logic [AW-1:0]  addr;
      logic           we;

      assign rsel = (q_data.r0[0] == RP) ? q_data.r0 : q_data.r1;
      assign csel = (q_data.c0[0] == CP) ? q_data.c0 : q_data.c1;
      assign addr = {rsel[RB:1], csel[CB:1]};
      assign we   = q_pop && q_data.is_write && q_data.wr_ok &&
                    (q_data.r0[0] == RP) && (q_data.c0[0] == CP);

      always_ff @(posedge clock) begin
         if (we) begin
            mem[addr] <= q_data.pixel;
         end
         if (q_pop) begin
            rd_ff <= mem[addr];
         end
      end

      assign rd_bank[b] = rd_ff;
   end

   // weights from the fractions
   always_comb begin
      ir       = WW'(256) - WW'(q_data.fr);
      ic       = WW'(256) - WW'(q_data.fc);
      w00_prod = PRW'(ir) * PRW'(ic);
      w10_prod = PRW'(q_data.fr) * PRW'(ic);
      w01_prod = PRW'(ir) * PRW'(q_data.fc);
      w11_prod = PRW'(q_data.fr) * PRW'(q_data.fc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff <= q_pop && !q_data.is_write;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         w00_ff    <= w00_prod[WW+7:8];
         w10_ff    <= w10_prod[WW+7:8];
         w01_ff    <= w01_prod[WW+7:8];
         w11_ff    <= w11_prod[WW+7:8];
         rs0_ff    <= q_data.r0[0];
         rs1_ff    <= q_data.r1[0];
         cs0_ff    <= q_data.c0[0];
         cs1_ff    <= q_data.c1[0];
         b1_row_ff <= q_data.row;
         b1_col_ff <= q_data.col;
      end
   end

   // route bank data to neighbours and form the weighted sum
   always_comb begin
      p00 = rd_bank[{rs0_ff, cs0_ff}];
      p10 = rd_bank[{rs1_ff, cs0_ff}];
      p01 = rd_bank[{rs0_ff, cs1_ff}];
      p11 = rd_bank[{rs1_ff, cs1_ff}];
      sum = SUMW'(p00) * SUMW'(w00_ff) + SUMW'(p10) * SUMW'(w10_ff)
          + SUMW'(p01) * SUMW'(w01_ff) + SUMW'(p11) * SUMW'(w11_ff);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en && b1_valid_ff) begin
         out_pix_ff <= sum[PXW+7:8];
         out_row_ff <= b1_row_ff;
         out_col_ff <= b1_col_ff;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.pixel_out = out_pix_ff;
   assign rsp_ch.out_row   = out_row_ff;
   assign rsp_ch.out_col   = out_col_ff;

endmodule

`default_nettype wire

// ===== rtl/bilinear_grayscale_scaler.sv =====
// bilinear_grayscale_scaler: top level with configuration registers, front, queue and back
// depends on bls_pkg, bls_req_if, bls_rsp_if, bls_front, bls_queue and bls_back
//
// usage:
//   req_ch carries requests: req_type 0 stores pixel_in at (row, col) in the
//   frame store, req_type 1 asks for the interpolated output pixel at output
//   (row, col). rsp_ch returns one result (pixel_out, out_row, out_col) per
//   interpolation request, in request order; store writes return nothing.
//   csr_we/csr_index/csr_wdata write src_width, src_height, row_step and
//   col_step; write them only while no request is in flight.
//   throughput is one request per cycle while req_ch.ready is high; the frame
//   store is split into four banks by row and column parity so all four
//   neighbours are read in the same cycle. from acceptance to rsp_ch.valid a
//   request passes two front stages (multiply, clamp), the queue, the bank read
//   with weights, and the output register holding the weighted sum.
//   a write is visible to every request accepted after it.
//   reset clears the pipeline and queue and restores register defaults; the
//   frame store is not cleared and holds garbage until written.
//   when rsp_ch.ready is low the back holds, the queue fills, and req_ch.ready
//   drops only once the queue is full.
`default_nettype none

module bilinear_grayscale_scaler #(
   parameter int MAX_SRC_WIDTH  = bls_pkg::DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = bls_pkg::DEF_MAX_SRC_HEIGHT,
   parameter int FRAC_BITS      = bls_pkg::DEF_FRAC_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bls_req_if.sink                               req_ch,
   bls_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [bls_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  wire logic [bls_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bls_pkg::bls_cfg_type cfg_ff;
   bls_pkg::bls_cfg_type cfg_in;
   bls_pkg::bls_cmd_type push_data;
   bls_pkg::bls_cmd_type pop_data;
   logic                 push;
   logic                 pop;
   logic                 full;
   logic                 empty;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bls_pkg::CSR_SRC_WIDTH: begin
               cfg_in.src_width = csr_wdata[bls_pkg::DIM_W-1:0];
            end
            bls_pkg::CSR_SRC_HEIGHT: begin
               cfg_in.src_height = csr_wdata[bls_pkg::DIM_W-1:0];
            end
            bls_pkg::CSR_ROW_STEP: begin
               cfg_in.row_step = csr_wdata[bls_pkg::STEP_W-1:0];
            end
            bls_pkg::CSR_COL_STEP: begin
               cfg_in.col_step = csr_wdata[bls_pkg::STEP_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= bls_pkg::RST_SRC_WIDTH;
         cfg_ff.src_height <= bls_pkg::RST_SRC_HEIGHT;
         cfg_ff.row_step   <= bls_pkg::RST_ROW_STEP;
         cfg_ff.col_step   <= bls_pkg::RST_COL_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bls_front #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .FRAC_BITS      (FRAC_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cfg    (cfg_ff),
      .q_full (full),
      .q_push (push),
      .q_data (push_data)
   );

   bls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   bls_back #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (empty),
      .q_pop   (pop),
      .q_data  (pop_data),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== tb/bls_result_check.sv =====
`timescale 1ns / 100ps
// bls_result_check: watches the request, result and register ports of the scaler,
// predicts every interpolated pixel and compares results in order
// depends on bls_pkg and the bls_req_if / bls_rsp_if channel interfaces
module bls_result_check (
   input  logic                              clock,
   input  logic                              reset,
   bls_req_if                                req_ch,
   bls_rsp_if                                rsp_ch,
   input  logic                              csr_we,
   input  logic [bls_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [bls_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                fail_count,
   output int                                pending
);
   import bls_pkg::*;

   localparam int MAX_W     = DEF_MAX_SRC_WIDTH;
   localparam int MAX_H     = DEF_MAX_SRC_HEIGHT;
   localparam int FRAC_BITS = DEF_FRAC_BITS;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } scaled_pixel_t;

   // shadow of the frame store, register file and pixels still owed
   scaled_pixel_t     expected_pixels[$];
   logic [PIX_W-1:0]  frame_copy [MAX_W*MAX_H];
   logic [DIM_W-1:0]  width_reg;
   logic [DIM_W-1:0]  height_reg;
   logic [STEP_W-1:0] row_step_reg;
   logic [STEP_W-1:0] col_step_reg;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   // zero counts as one, oversize saturates at the store dimension
   function automatic int effective_dim(input logic [DIM_W-1:0] v, input int limit);
      if (v == 0)
         return 1;
      if (v > limit)
         return limit;
      return int'(v);
   endfunction

   // coordinate times step, split into clamped neighbour pair and 8-bit fraction
   function automatic void locate(input logic [COORD_W-1:0] coord,
                                  input logic [STEP_W-1:0] step, input int dim,
                                  output logic [COORD_W-1:0] i0,
                                  output logic [COORD_W-1:0] i1,
                                  output logic [FRAC_W-1:0] frac);
      logic [PROD_W-1:0]  pos;
      logic [PROD_W-1:0]  whole;
      logic [COORD_W-1:0] last;
      pos   = PROD_W'(coord) * PROD_W'(step);
      whole = pos >> FRAC_BITS;
      frac  = pos[FRAC_BITS-1 -: FRAC_W];
      last  = COORD_W'(dim - 1);
      i0    = (whole > PROD_W'(last)) ? last : whole[COORD_W-1:0];
      i1    = (i0 < last) ? i0 + COORD_W'(1) : last;
   endfunction

   function automatic scaled_pixel_t interpolate(input logic [COORD_W-1:0] orow,
                                                 input logic [COORD_W-1:0] ocol);
      logic [COORD_W-1:0] r0, r1, c0, c1;
      logic [FRAC_W-1:0]  fr, fc;
      logic [WGT_W-1:0]   ir, ic, w00, w10, w01, w11;
      int                 sum;
      scaled_pixel_t      res;
      locate(orow, row_step_reg, effective_dim(height_reg, MAX_H), r0, r1, fr);
      locate(ocol, col_step_reg, effective_dim(width_reg, MAX_W), c0, c1, fc);
      ir  = WGT_W'(256) - WGT_W'(fr);
      ic  = WGT_W'(256) - WGT_W'(fc);
      // truncated 9-bit weights
      w00 = WGT_W'((int'(ir) * int'(ic)) >> 8);
      w10 = WGT_W'((int'(fr) * int'(ic)) >> 8);
      w01 = WGT_W'((int'(ir) * int'(fc)) >> 8);
      w11 = WGT_W'((int'(fr) * int'(fc)) >> 8);
      sum = int'(frame_copy[int'(r0)*MAX_W + int'(c0)]) * int'(w00)
          + int'(frame_copy[int'(r1)*MAX_W + int'(c0)]) * int'(w10)
          + int'(frame_copy[int'(r0)*MAX_W + int'(c1)]) * int'(w01)
          + int'(frame_copy[int'(r1)*MAX_W + int'(c1)]) * int'(w11);
      res.pixel = PIX_W'(sum >> 8);
      res.row   = orow;
      res.col   = ocol;
      return res;
   endfunction

   always @(posedge clock) begin
      scaled_pixel_t got;
      scaled_pixel_t want;
      if (reset) begin
         width_reg    = RST_SRC_WIDTH;
         height_reg   = RST_SRC_HEIGHT;
         row_step_reg = RST_ROW_STEP;
         col_step_reg = RST_COL_STEP;
         expected_pixels.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:  width_reg    = csr_wdata[DIM_W-1:0];
               CSR_SRC_HEIGHT: height_reg   = csr_wdata[DIM_W-1:0];
               CSR_ROW_STEP:   row_step_reg = csr_wdata[STEP_W-1:0];
               CSR_COL_STEP:   col_step_reg = csr_wdata[STEP_W-1:0];
               default: ;
            endcase
         end
         // result against the oldest owed pixel
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.pixel = rsp_ch.pixel_out;
            got.row   = rsp_ch.out_row;
            got.col   = rsp_ch.out_col;
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result (%0d,%0d)=%0d with no request pending",
                                         got.row, got.col, got.pixel));
            end else begin
               want = expected_pixels.pop_front();
               if (got.pixel !== want.pixel)
                  report_mismatch($sformatf("pixel_out at (%0d,%0d): got %0d, want %0d",
                                            want.row, want.col, got.pixel, want.pixel));
               if (got.row !== want.row)
                  report_mismatch($sformatf("out_row: got %0d, want %0d", got.row, want.row));
               if (got.col !== want.col)
                  report_mismatch($sformatf("out_col: got %0d, want %0d", got.col, want.col));
            end
         end
         // request: store write or new owed pixel
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.req_type == REQ_WRITE) begin
               if (req_ch.row < MAX_H && req_ch.col < MAX_W)
                  frame_copy[int'(req_ch.row)*MAX_W + int'(req_ch.col)] = req_ch.pixel_in;
            end else begin
               expected_pixels.push_back(interpolate(req_ch.row, req_ch.col));
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: top of the bilinear scaler bench; drives requests and registers, gives the verdict
// depends on bls_pkg, bls_req_if / bls_rsp_if, bilinear_grayscale_scaler and bls_result_check
module testbench;
   import bls_pkg::*;

   localparam int MAX_W        = DEF_MAX_SRC_WIDTH;
   localparam int MAX_H        = DEF_MAX_SRC_HEIGHT;
   localparam int NUM_PHASES   = 12;
   localparam int MIX_ITEMS    = 60;
   localparam int IDLE_PCT     = 34;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    calm;
   int                    cycle_count;
   int                    fail_count;
   int                    pending;
   // store entries written so far; requests never touch any other
   bit                    written_map [MAX_W*MAX_H];
   int                    eff_w, eff_h, out_w, out_h;

   bls_req_if req_ch ();
   bls_rsp_if rsp_ch ();

   bilinear_grayscale_scaler dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bls_result_check result_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // one request, with random idle cycles ahead of it
   task automatic send_req(input logic kind, input logic [COORD_W-1:0] r,
                           input logic [COORD_W-1:0] c, input logic [PIX_W-1:0] px);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.row      <= r;
      req_ch.col      <= c;
      req_ch.pixel_in <= px;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (kind == REQ_WRITE && r < MAX_H && c < MAX_W)
         written_map[int'(r)*MAX_W + int'(c)] = 1'b1;
   endtask

   // drop valid and let every owed result and the pipeline drain
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic program_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [STEP_W-1:0] rs, input logic [STEP_W-1:0] cs);
      wait_idle();
      csr_write(CSR_SRC_WIDTH, CSR_DATA_W'(w));
      csr_write(CSR_SRC_HEIGHT, CSR_DATA_W'(h));
      csr_write(CSR_ROW_STEP, CSR_DATA_W'(rs));
      csr_write(CSR_COL_STEP, CSR_DATA_W'(cs));
   endtask

   // mostly a true scale factor dim/out, sometimes zero, maximum or any step
   task automatic pick_step(input int dim, output logic [STEP_W-1:0] step, output int span);
      int     k;
      int     out_n;
      longint q;
      k = $urandom_range(0, 9);
      if (k < 6) begin
         out_n = $urandom_range(1, 3*dim);
         q     = (longint'(dim) << 16) / out_n;
         step  = (q > 24'hFFFFFF) ? 24'hFFFFFF : STEP_W'(q);
         span  = out_n;
      end else if (k == 6) begin
         step = '0;
         span = 4;
      end else if (k == 7) begin
         step = 24'hFFFFFF;
         span = 4;
      end else begin
         step = STEP_W'($urandom());
         span = 8;
      end
   endtask

   initial begin
      logic [DIM_W-1:0]   w_raw, h_raw;
      logic [STEP_W-1:0]  rs, cs;
      logic [COORD_W-1:0] rr, cc;
      int                 pick;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_SRC_WIDTH;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_WRITE;
      req_ch.row      = '0;
      req_ch.col      = '0;
      req_ch.pixel_in = '0;
      rsp_ch.ready    = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner block: bright 2x2 inside a dark 3x3, plus the far corner
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            send_req(REQ_WRITE, COORD_W'(r), COORD_W'(c), (r < 2 && c < 2) ? 8'hFF : 8'h00);
      send_req(REQ_WRITE, 12'd255, 12'd255, 8'hA5);
      // writes off the store are dropped
      send_req(REQ_WRITE, 12'd256, 12'd0, PIX_W'($urandom()));
      send_req(REQ_WRITE, 12'd0, 12'd256, PIX_W'($urandom()));
      send_req(REQ_WRITE, 12'hFFF, 12'hFFF, PIX_W'($urandom()));
      // reset geometry: unit steps, far positions saturate at the last row and column
      send_req(REQ_READ, 12'd0, 12'd0, PIX_W'($urandom()));
      send_req(REQ_READ, 12'd1, 12'd1, PIX_W'($urandom()));
      send_req(REQ_READ, 12'd255, 12'd255, PIX_W'($urandom()));
      send_req(REQ_READ, 12'hFFF, 12'hFFF, PIX_W'($urandom()));
      // half steps on a 3x3 frame: all-bright mix, edge with kept fraction
      program_frame(9'd3, 9'd3, 24'h008000, 24'h008000);
      send_req(REQ_READ, 12'd0, 12'd0, PIX_W'($urandom()));
      send_req(REQ_READ, 12'd1, 12'd1, PIX_W'($urandom()));
      send_req(REQ_READ, 12'd3, 12'd3, PIX_W'($urandom()));
      send_req(REQ_READ, 12'd5, 12'd5, PIX_W'($urandom()));

      for (int p = 0; p < NUM_PHASES; p++) begin
         calm = (p == 4 || p == 5);
         case (p)
            0: begin
               // zero sizes count as one pixel, zero steps
               w_raw = '0; h_raw = '0; eff_w = 1; eff_h = 1;
               rs = '0; cs = '0; out_h = 4; out_w = 4;
            end
            1: begin
               w_raw = 9'd256; h_raw = 9'd1; eff_w = 256; eff_h = 1;
               rs = 24'hFFFFFF; out_h = 4;
               pick_step(256, cs, out_w);
            end
            2: begin
               // oversize width saturates at the store width
               w_raw = 9'h1FF; h_raw = '0; eff_w = 256; eff_h = 1;
               pick_step(1, rs, out_h);
               cs = 24'hFFFFFF; out_w = 4;
            end
            3: begin
               w_raw = 9'd1; h_raw = 9'd256; eff_w = 1; eff_h = 256;
               pick_step(256, rs, out_h);
               cs = '0; out_w = 4;
            end
            default: begin
               eff_w = $urandom_range(1, 8);
               eff_h = $urandom_range(1, 8);
               w_raw = DIM_W'(eff_w);
               h_raw = DIM_W'(eff_h);
               pick_step(eff_h, rs, out_h);
               pick_step(eff_w, cs, out_w);
            end
         endcase
         program_frame(w_raw, h_raw, rs, cs);

         // fill whatever part of the frame is still unwritten
         for (int r = 0; r < eff_h; r++)
            for (int c = 0; c < eff_w; c++)
               if (!written_map[r*MAX_W + c])
                  send_req(REQ_WRITE, COORD_W'(r), COORD_W'(c), PIX_W'($urandom()));

         // mixed traffic: mostly interpolations over the output grid
         for (int i = 0; i < MIX_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               if ($urandom_range(0, 9) == 0) begin
                  rr = COORD_W'($urandom());
                  cc = COORD_W'($urandom());
               end else begin
                  rr = COORD_W'($urandom_range(0, out_h + 1));
                  cc = COORD_W'($urandom_range(0, out_w + 1));
               end
               send_req(REQ_READ, rr, cc, PIX_W'($urandom()));
            end else if (pick < 85) begin
               send_req(REQ_WRITE, COORD_W'($urandom_range(0, eff_h - 1)),
                        COORD_W'($urandom_range(0, eff_w - 1)), PIX_W'($urandom()));
            end else if (pick < 93) begin
               send_req(REQ_WRITE, COORD_W'($urandom_range(0, MAX_H - 1)),
                        COORD_W'($urandom_range(0, MAX_W - 1)), PIX_W'($urandom()));
            end else begin
               if ($urandom_range(0, 1) == 1) begin
                  rr = COORD_W'($urandom_range(MAX_H, 4095));
                  cc = COORD_W'($urandom());
               end else begin
                  rr = COORD_W'($urandom());
                  cc = COORD_W'($urandom_range(MAX_W, 4095));
               end
               send_req(REQ_WRITE, rr, cc, PIX_W'($urandom()));
            end
         end
      end
      calm = 1'b0;

      wait_idle();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
